// ----- src/brfalu_pkg.sv -----
// Package: shared types, codes and defaults for the register file logic ALU.
`default_nettype none
package brfalu_pkg;

  localparam int NUM_VARS_DEF   = 26;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int IDX_W          = 5;
  localparam int VAL_W          = 32;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_LOGIC = 2'd1;
  localparam logic [1:0] FUNC_NOT   = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [3:0] LOP_OR   = 4'd0;
  localparam logic [3:0] LOP_AND  = 4'd1;
  localparam logic [3:0] LOP_IMP  = 4'd2;
  localparam logic [3:0] LOP_CONV = 4'd3;
  localparam logic [3:0] LOP_EQV  = 4'd4;
  localparam logic [3:0] LOP_XOR  = 4'd5;
  localparam logic [3:0] LOP_INH  = 4'd6;
  localparam logic [3:0] LOP_NAND = 4'd7;
  localparam logic [3:0] LOP_NOR  = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDEF = 2'd1;
  localparam logic [1:0] ST_BADOP = 2'd2;
  localparam logic [1:0] ST_HALT  = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] dest;
    logic [IDX_W-1:0] src_a;
    logic [IDX_W-1:0] src_b;
    logic [3:0]       logic_op;
    logic [VAL_W-1:0] load_value;
  } in_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] result_value;
    logic [1:0]       status;
  } out_rsp_t;

endpackage
`default_nettype wire

// ----- src/brfalu_ram.sv -----
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module brfalu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 26
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// ----- src/boolean_register_file_alu_top.sv -----
// Top level: register file with bitwise logic unit and halt latch.
//
//  channel | ports                         | payload
//  --------+-------------------------------+-------------------------
//  in      | in_valid, in_stall, in_req    | brfalu_pkg::in_req_t
//  out     | out_valid, out_stall, out_rsp | brfalu_pkg::out_rsp_t
//
// One request per cycle while in_stall is low. The first stage registers the
// request and reads the variable RAM; the second computes, writes back and loads
// the output register; its write is forwarded to the request being read.
// Reset clears the defined flags and the halt latch; RAM contents are left as is.
// A stalled output holds the second stage, which then stalls the input.
`default_nettype none
module boolean_register_file_alu_top #(
  parameter int NUM_VARS   = brfalu_pkg::NUM_VARS_DEF,
  parameter int DATA_WIDTH = brfalu_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire brfalu_pkg::in_req_t  in_req,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output brfalu_pkg::out_rsp_t      out_rsp
);

  localparam int AW = $clog2(NUM_VARS);

  logic                  s1_valid_r;
  brfalu_pkg::in_req_t   s1_req_r;
  logic                  fwd_a_r;
  logic                  fwd_b_r;
  logic [DATA_WIDTH-1:0] fwd_data_r;
  logic [NUM_VARS-1:0]   def_r;
  logic                  halted_r;
  logic                  out_valid_r;
  brfalu_pkg::out_rsp_t  out_rsp_r;

  logic                  accept;
  logic                  adv;
  logic [AW-1:0]         rd_addr_a;
  logic [AW-1:0]         rd_addr_b;
  logic [DATA_WIDTH-1:0] ram_a;
  logic [DATA_WIDTH-1:0] ram_b;
  logic [AW-1:0]         addr_a;
  logic [AW-1:0]         addr_b;
  logic [AW-1:0]         addr_d;
  logic                  rng_a;
  logic                  rng_b;
  logic                  rng_d;
  logic                  def_a;
  logic                  def_b;
  logic [DATA_WIDTH-1:0] val_a;
  logic [DATA_WIDTH-1:0] val_b;
  logic [DATA_WIDTH-1:0] res;
  logic [1:0]            st;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic                  ram_we;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign ram_we   = adv && wr_en;

  assign rd_addr_a = AW'(in_req.src_a);
  assign rd_addr_b = AW'(in_req.src_b);

  brfalu_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_VARS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wr_addr),
    .wdata   (res),
    .re      (accept),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  assign addr_a = AW'(s1_req_r.src_a);
  assign addr_b = AW'(s1_req_r.src_b);
  assign addr_d = AW'(s1_req_r.dest);
  assign rng_a  = 32'(s1_req_r.src_a) < 32'(NUM_VARS);
  assign rng_b  = 32'(s1_req_r.src_b) < 32'(NUM_VARS);
  assign rng_d  = 32'(s1_req_r.dest) < 32'(NUM_VARS);
  assign def_a  = rng_a && def_r[addr_a];
  assign def_b  = rng_b && def_r[addr_b];
  assign val_a  = fwd_a_r ? fwd_data_r : ram_a;
  assign val_b  = fwd_b_r ? fwd_data_r : ram_b;

  always_comb begin
    res     = '0;
    st      = brfalu_pkg::ST_OK;
    wr_en   = 1'b0;
    wr_addr = addr_d;
    if (halted_r) begin
      st = brfalu_pkg::ST_HALT;
    end else begin
      unique case (s1_req_r.func)
        brfalu_pkg::FUNC_LOAD: begin
          res   = DATA_WIDTH'(s1_req_r.load_value);
          wr_en = rng_d;
        end
        brfalu_pkg::FUNC_LOGIC: begin
          if (!def_a || !def_b) begin
            st = brfalu_pkg::ST_UNDEF;
          end else begin
            unique case (s1_req_r.logic_op)
              brfalu_pkg::LOP_OR:   res = val_a | val_b;
              brfalu_pkg::LOP_AND:  res = val_a & val_b;
              brfalu_pkg::LOP_IMP:  res = ~val_a | val_b;
              brfalu_pkg::LOP_CONV: res = ~val_b | val_a;
              brfalu_pkg::LOP_EQV:  res = ~(val_a ^ val_b);
              brfalu_pkg::LOP_XOR:  res = val_a ^ val_b;
              brfalu_pkg::LOP_INH:  res = val_a & ~val_b;
              brfalu_pkg::LOP_NAND: res = ~(val_a & val_b);
              brfalu_pkg::LOP_NOR:  res = ~(val_a | val_b);
              default:              st  = brfalu_pkg::ST_BADOP;
            endcase
            wr_en = rng_d && (st == brfalu_pkg::ST_OK);
          end
        end
        brfalu_pkg::FUNC_NOT: begin
          if (!def_a) begin
            st = brfalu_pkg::ST_UNDEF;
          end else begin
            res   = ~val_a;
            wr_en = rng_d;
          end
        end
        brfalu_pkg::FUNC_READ: begin
          // unset variable reads as 0 and becomes defined
          wr_addr = addr_a;
          wr_en   = rng_a && !def_a;
          res     = def_a ? val_a : '0;
        end
      endcase
    end
    if (st != brfalu_pkg::ST_OK) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      def_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        def_r[wr_addr] <= 1'b1;
      end
      if (adv && (st == brfalu_pkg::ST_UNDEF || st == brfalu_pkg::ST_BADOP)) begin
        halted_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r   <= in_req;
      fwd_a_r    <= ram_we && (wr_addr == rd_addr_a);
      fwd_b_r    <= ram_we && (wr_addr == rd_addr_b);
      fwd_data_r <= res;
    end
    if (adv) begin
      out_rsp_r.result_value <= brfalu_pkg::VAL_W'(res);
      out_rsp_r.status       <= st;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire
